/* sv/ispe_pkg.sv */
// Shared types and constants for the ISP programmer EEPROM cache engine.
// Used by every module of the block.
package ispe_pkg;

   localparam int CACHE_BYTES = 512;
   localparam int CACHE_AW    = $clog2(CACHE_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] ACT_SETUP    = 2'd0;
   localparam logic [1:0] ACT_DATA_OUT = 2'd1;
   localparam logic [1:0] ACT_DATA_IN  = 2'd2;
   localparam logic [1:0] ACT_ENG_DONE = 2'd3;

   localparam logic [7:0] REQ_CONNECT    = 8'd1;
   localparam logic [7:0] REQ_DISCONNECT = 8'd2;
   localparam logic [7:0] REQ_TRANSMIT   = 8'd3;
   localparam logic [7:0] REQ_READ_FLASH = 8'd4;
   localparam logic [7:0] REQ_ENABLE     = 8'd5;
   localparam logic [7:0] REQ_WRITE_FLASH = 8'd6;
   localparam logic [7:0] REQ_READ_EE    = 8'd7;
   localparam logic [7:0] REQ_WRITE_EE   = 8'd8;
   localparam logic [7:0] REQ_LONG_ADDR  = 8'd9;
   localparam logic [7:0] REQ_SET_CLOCK  = 8'd10;

   localparam logic [7:0] TX_SIG      = 8'h30;
   localparam logic [7:0] TX_FF       = 8'hff;
   localparam logic [7:0] TX_LFUSE    = 8'h50;
   localparam logic [7:0] TX_FUSE     = 8'h58;
   localparam logic [7:0] TX_HI_FUSE  = 8'h08;
   localparam logic [7:0] TX_RD_CELL  = 8'ha0;
   localparam logic [7:0] TX_WR_CELL  = 8'hc0;
   localparam logic [15:0] TX_TYPE_IDX = 16'h80ff;
   localparam logic [7:0] FUSE_VALUE  = 8'h3f;
   localparam logic [7:0] LOCK_VALUE  = 8'hc0;
   localparam logic [7:0] TYPE_B0     = 8'had;
   localparam logic [7:0] TYPE_B1     = 8'h93;
   localparam logic [7:0] TYPE_B2     = 8'hcc;
   localparam logic [7:0] EE_TYPE_RESET = 8'h66;
   localparam logic [7:0] ERASED_BYTE = 8'hff;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_WRONG    = 2'd2;

   typedef enum logic [2:0] {
      TM_IDLE, TM_WFLASH, TM_RFLASH, TM_WEE, TM_REE
   } tmode_type;

   typedef enum logic [1:0] {
      EM_IDLE, EM_READ, EM_WRITE
   } emode_type;

   typedef enum logic [3:0] {
      C_NONE, C_CONNECT, C_DISCONNECT, C_ENABLE, C_SET_CLOCK, C_TRANSMIT,
      C_LONG_ADDR, C_WFLASH, C_RFLASH, C_REE, C_WEE, C_DATA_OUT, C_DATA_IN,
      C_ENG_DONE
   } kind_type;

   typedef enum logic [2:0] {
      BS_IDLE, BS_EXEC, BS_WLOOP, BS_RLOOP, BS_TRD, BS_TWR
   } bstate_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] pk;
      logic [3:0]  len;
      logic        eng_idle;
   } cmd_type;

   typedef struct packed {
      logic [63:0] reply_bytes;
      logic [3:0]  reply_len;
      logic        data_stage;
      logic [1:0]  transfer_status;
      logic        connected;
      logic        keep_running;
      logic        start_writeback;
   } rsp_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = 8'h1e;
         2'd1: b = 8'h93;
         2'd2: b = 8'h07;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* sv/ispe_req_if.sv */
// Request channel of the EEPROM cache engine: valid, ready and one event.
// Depends on nothing.
interface ispe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] packet_bytes;
   logic [3:0]  packet_len;
   logic        engine_idle;

   modport source(output valid, action, packet_bytes, packet_len, engine_idle,
                  input ready);
   modport sink(input valid, action, packet_bytes, packet_len, engine_idle,
                output ready);
endinterface

/* sv/ispe_rsp_if.sv */
// Response channel of the EEPROM cache engine: valid, ready and one result.
// Depends on nothing.
interface ispe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] reply_bytes;
   logic [3:0]  reply_len;
   logic        data_stage;
   logic [1:0]  transfer_status;
   logic        connected;
   logic        keep_running;
   logic        start_writeback;

   modport source(output valid, reply_bytes, reply_len, data_stage, transfer_status,
                  connected, keep_running, start_writeback, input ready);
   modport sink(input valid, reply_bytes, reply_len, data_stage, transfer_status,
                connected, keep_running, start_writeback, output ready);
endinterface

/* sv/ispe_front.sv */
// Front end: classifies each accepted event into a command for the queue.
// Depends on ispe_pkg.
module ispe_front (
   input  logic              valid,
   input  logic [1:0]        action,
   input  logic [63:0]       packet_bytes,
   input  logic [3:0]        packet_len,
   input  logic              engine_idle,
   input  logic              q_full,
   output logic              ready,
   output logic              q_push,
   output ispe_pkg::cmd_type q_data
);

   ispe_pkg::kind_type kind;

   always_comb begin
      kind = ispe_pkg::C_NONE;
      case (action)
         ispe_pkg::ACT_SETUP: begin
            if (packet_bytes[6:5] == 2'b10) begin
               case (packet_bytes[15:8])
                  ispe_pkg::REQ_CONNECT:     kind = ispe_pkg::C_CONNECT;
                  ispe_pkg::REQ_DISCONNECT:  kind = ispe_pkg::C_DISCONNECT;
                  ispe_pkg::REQ_TRANSMIT:    kind = ispe_pkg::C_TRANSMIT;
                  ispe_pkg::REQ_READ_FLASH:  kind = ispe_pkg::C_RFLASH;
                  ispe_pkg::REQ_ENABLE:      kind = ispe_pkg::C_ENABLE;
                  ispe_pkg::REQ_WRITE_FLASH: kind = ispe_pkg::C_WFLASH;
                  ispe_pkg::REQ_READ_EE:     kind = ispe_pkg::C_REE;
                  ispe_pkg::REQ_WRITE_EE:    kind = ispe_pkg::C_WEE;
                  ispe_pkg::REQ_LONG_ADDR:   kind = ispe_pkg::C_LONG_ADDR;
                  ispe_pkg::REQ_SET_CLOCK:   kind = ispe_pkg::C_SET_CLOCK;
                  default:                   kind = ispe_pkg::C_NONE;
               endcase
            end
         end
         ispe_pkg::ACT_DATA_OUT: kind = ispe_pkg::C_DATA_OUT;
         ispe_pkg::ACT_DATA_IN:  kind = ispe_pkg::C_DATA_IN;
         default:                kind = ispe_pkg::C_ENG_DONE;
      endcase
   end

   assign ready = !q_full;
   assign q_push = valid && !q_full;
   assign q_data.kind = kind;
   assign q_data.pk = packet_bytes;
   assign q_data.len = (packet_len > 4'd8) ? 4'd8 : packet_len;
   assign q_data.eng_idle = engine_idle;

endmodule

/* sv/ispe_queue.sv */
// Short command queue between the front end and the execution unit.
// Depends on ispe_pkg.
module ispe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ispe_pkg::cmd_type push_data,
   input  logic              pop,
   output ispe_pkg::cmd_type pop_data,
   output logic              full,
   output logic              empty
);

   ispe_pkg::cmd_type entry_ff [ispe_pkg::QUEUE_DEPTH];
   logic [ispe_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ispe_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ispe_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign full = count_ff == (ispe_pkg::QUEUE_AW + 1)'(ispe_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/ispe_back.sv */
// Execution unit: programmer state, byte cache memory and result register.
// Depends on ispe_pkg.
module ispe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ispe_pkg::cmd_type q_data,
   output logic              q_pop,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ispe_pkg::rsp_type rsp_data
);

   localparam logic [31:0] CacheLimit = 32'(ispe_pkg::CACHE_BYTES);

   logic [7:0] cache_mem [ispe_pkg::CACHE_BYTES];
   logic [7:0] rdata_ff;

   ispe_pkg::bstate_type state_ff, state_in;
   ispe_pkg::cmd_type    cmd_ff, cmd_in;
   ispe_pkg::tmode_type  tmode_ff, tmode_in;
   ispe_pkg::emode_type  emode_ff, emode_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic        long_ff, long_in;
   logic [1:0]  exit_ff, exit_in;
   logic        dirty_ff, dirty_in;
   logic [7:0]  type_ff;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] reply_ff, reply_in;
   logic        out_valid_ff, out_valid_in;
   ispe_pkg::rsp_type out_ff;

   logic        finish;
   logic [3:0]  f_len;
   logic        f_stage;
   logic [1:0]  f_status;
   logic        f_wb;
   logic        mem_we;
   logic [ispe_pkg::CACHE_AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata;

   logic [7:0]  vlo, vhi, ilo, ihi, wbyte;
   logic [31:0] cell_addr;
   logic        cell_ok, addr_ok, last_idx;

   assign vlo = cmd_ff.pk[23:16];
   assign vhi = cmd_ff.pk[31:24];
   assign ilo = cmd_ff.pk[39:32];
   assign ihi = cmd_ff.pk[47:40];
   assign cell_addr = {23'd0, vhi[0], ilo};
   assign cell_ok = cell_addr < CacheLimit;
   assign addr_ok = addr_ff < CacheLimit;
   assign wbyte = cmd_ff.pk[{idx_ff[2:0], 3'b000} +: 8];
   assign last_idx = (idx_ff + 4'd1) == cmd_ff.len;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      tmode_in = tmode_ff;
      emode_in = emode_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      long_in = long_ff;
      exit_in = exit_ff;
      dirty_in = dirty_ff;
      idx_in = idx_ff;
      reply_in = reply_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      q_pop = 1'b0;
      finish = 1'b0;
      f_len = 4'd0;
      f_stage = 1'b0;
      f_status = ispe_pkg::ST_OK;
      f_wb = 1'b0;
      mem_we = 1'b0;
      mem_waddr = addr_ff[ispe_pkg::CACHE_AW-1:0];
      mem_wdata = wbyte;
      mem_raddr = addr_in[ispe_pkg::CACHE_AW-1:0];

      case (state_ff)
         ispe_pkg::BS_IDLE: begin
            if (!q_empty && !out_valid_ff) begin
               q_pop = 1'b1;
               cmd_in = q_data;
               reply_in = '0;
               idx_in = 4'd0;
               state_in = ispe_pkg::BS_EXEC;
            end
         end
         ispe_pkg::BS_EXEC: begin
            finish = 1'b1;
            case (cmd_ff.kind)
               ispe_pkg::C_CONNECT: begin
                  long_in = 1'b0;
                  exit_in = exit_ff | 2'b10;
               end
               ispe_pkg::C_DISCONNECT: begin
                  exit_in = exit_ff & 2'b01;
                  if (dirty_ff && cmd_ff.eng_idle && emode_ff == ispe_pkg::EM_IDLE) begin
                     emode_in = ispe_pkg::EM_WRITE;
                     f_wb = 1'b1;
                  end
               end
               ispe_pkg::C_ENABLE: begin
                  reply_in[7:0] = {7'd0, emode_ff != ispe_pkg::EM_IDLE};
                  f_len = 4'd1;
               end
               ispe_pkg::C_SET_CLOCK: f_len = 4'd1;
               ispe_pkg::C_TRANSMIT: begin
                  f_len = 4'd4;
                  if (vlo == ispe_pkg::TX_SIG) begin
                     reply_in[31:24] = ispe_pkg::sig_byte(ilo[1:0]);
                  end else if ({vhi, vlo} == 16'hffff && {ihi, ilo} == 16'hffff) begin
                     exit_in = exit_ff & 2'b10;
                  end else if (vlo == ispe_pkg::TX_FF && vhi == 8'd0) begin
                     exit_in = exit_ff & 2'b10;
                  end else if ({vhi, vlo} == 16'hffff && {ihi, ilo} == ispe_pkg::TX_TYPE_IDX)
                  begin
                     reply_in[31:0] = {type_ff, ispe_pkg::TYPE_B2, ispe_pkg::TYPE_B1,
                                       ispe_pkg::TYPE_B0};
                  end else if ((vlo == ispe_pkg::TX_FUSE || vlo == ispe_pkg::TX_LFUSE)
                               && vhi == 8'd0) begin
                     reply_in[31:24] = ispe_pkg::FUSE_VALUE;
                  end else if (vlo == ispe_pkg::TX_FUSE && vhi == ispe_pkg::TX_HI_FUSE) begin
                     reply_in[31:24] = ispe_pkg::LOCK_VALUE;
                  end else if (vlo == ispe_pkg::TX_RD_CELL && vhi[7:1] == 7'd0) begin
                     finish = 1'b0;
                     mem_raddr = cell_addr[ispe_pkg::CACHE_AW-1:0];
                     state_in = ispe_pkg::BS_TRD;
                  end else if (vlo == ispe_pkg::TX_WR_CELL && vhi[7:1] == 7'd0) begin
                     finish = 1'b0;
                     mem_raddr = cell_addr[ispe_pkg::CACHE_AW-1:0];
                     state_in = ispe_pkg::BS_TWR;
                  end else begin
                     reply_in[31:24] = ispe_pkg::ERASED_BYTE;
                  end
               end
               ispe_pkg::C_LONG_ADDR: begin
                  long_in = 1'b1;
                  addr_in = cmd_ff.pk[47:16];
               end
               ispe_pkg::C_WFLASH: begin
                  left_in = cmd_ff.pk[63:48];
                  tmode_in = ispe_pkg::TM_WFLASH;
                  f_stage = 1'b1;
               end
               ispe_pkg::C_RFLASH, ispe_pkg::C_REE, ispe_pkg::C_WEE: begin
                  if (!long_ff) begin
                     addr_in = {16'd0, cmd_ff.pk[31:16]};
                  end
                  left_in = cmd_ff.pk[63:48];
                  if (cmd_ff.kind == ispe_pkg::C_RFLASH) begin
                     tmode_in = ispe_pkg::TM_RFLASH;
                  end else if (cmd_ff.kind == ispe_pkg::C_REE) begin
                     tmode_in = ispe_pkg::TM_REE;
                  end else begin
                     tmode_in = ispe_pkg::TM_WEE;
                  end
                  f_stage = 1'b1;
               end
               ispe_pkg::C_DATA_OUT: begin
                  if (tmode_ff == ispe_pkg::TM_WFLASH) begin
                     if (left_ff > {12'd0, cmd_ff.len}) begin
                        left_in = left_ff - {12'd0, cmd_ff.len};
                     end else begin
                        left_in = 16'd0;
                        tmode_in = ispe_pkg::TM_IDLE;
                        f_status = ispe_pkg::ST_COMPLETE;
                     end
                  end else if (tmode_ff == ispe_pkg::TM_WEE) begin
                     if (cmd_ff.len != 4'd0) begin
                        finish = 1'b0;
                        state_in = ispe_pkg::BS_WLOOP;
                     end
                  end else begin
                     f_status = ispe_pkg::ST_WRONG;
                  end
               end
               ispe_pkg::C_DATA_IN: begin
                  if (tmode_ff == ispe_pkg::TM_RFLASH) begin
                     for (int i = 0; i < 8; i++) begin
                        if (4'(i) < cmd_ff.len) begin
                           reply_in[8*i +: 8] = ispe_pkg::ERASED_BYTE;
                        end
                     end
                     addr_in = addr_ff + {28'd0, cmd_ff.len};
                     if (cmd_ff.len < 4'd8) begin
                        tmode_in = ispe_pkg::TM_IDLE;
                     end
                     f_len = cmd_ff.len;
                  end else if (tmode_ff == ispe_pkg::TM_REE) begin
                     if (cmd_ff.len == 4'd0) begin
                        tmode_in = ispe_pkg::TM_IDLE;
                     end else begin
                        finish = 1'b0;
                        state_in = ispe_pkg::BS_RLOOP;
                     end
                  end else begin
                     f_status = ispe_pkg::ST_WRONG;
                  end
               end
               ispe_pkg::C_ENG_DONE: begin
                  if (emode_ff != ispe_pkg::EM_IDLE) begin
                     dirty_in = 1'b0;
                  end
                  emode_in = ispe_pkg::EM_IDLE;
               end
               default: ;
            endcase
         end
         ispe_pkg::BS_WLOOP: begin
            if (addr_ok) begin
               mem_we = 1'b1;
               if (rdata_ff != wbyte) begin
                  dirty_in = 1'b1;
               end
            end
            addr_in = addr_ff + 32'd1;
            left_in = left_ff - 16'd1;
            mem_raddr = addr_in[ispe_pkg::CACHE_AW-1:0];
            idx_in = idx_ff + 4'd1;
            if (left_in == 16'd0) begin
               tmode_in = ispe_pkg::TM_IDLE;
               f_status = ispe_pkg::ST_COMPLETE;
               finish = 1'b1;
            end else if (last_idx) begin
               finish = 1'b1;
            end
         end
         ispe_pkg::BS_RLOOP: begin
            reply_in[{idx_ff[2:0], 3'b000} +: 8] = addr_ok ? rdata_ff : ispe_pkg::ERASED_BYTE;
            addr_in = addr_ff + 32'd1;
            mem_raddr = addr_in[ispe_pkg::CACHE_AW-1:0];
            idx_in = idx_ff + 4'd1;
            if (last_idx) begin
               finish = 1'b1;
               f_len = cmd_ff.len;
               if (cmd_ff.len < 4'd8) begin
                  tmode_in = ispe_pkg::TM_IDLE;
               end
            end
         end
         ispe_pkg::BS_TRD: begin
            reply_in[31:24] = cell_ok ? rdata_ff : ispe_pkg::ERASED_BYTE;
            f_len = 4'd4;
            finish = 1'b1;
         end
         ispe_pkg::BS_TWR: begin
            mem_waddr = cell_addr[ispe_pkg::CACHE_AW-1:0];
            mem_wdata = ihi;
            if (cell_ok) begin
               mem_we = 1'b1;
               if (rdata_ff != ihi) begin
                  dirty_in = 1'b1;
               end
            end
            f_len = 4'd4;
            finish = 1'b1;
         end
         default: state_in = ispe_pkg::BS_IDLE;
      endcase

      if (finish) begin
         out_valid_in = 1'b1;
         state_in = ispe_pkg::BS_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ispe_pkg::BS_IDLE;
         tmode_ff <= ispe_pkg::TM_IDLE;
         emode_ff <= ispe_pkg::EM_READ;
         addr_ff <= '0;
         left_ff <= '0;
         long_ff <= 1'b0;
         exit_ff <= 2'b01;
         dirty_ff <= 1'b1;
         type_ff <= ispe_pkg::EE_TYPE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tmode_ff <= tmode_in;
         emode_ff <= emode_in;
         addr_ff <= addr_in;
         left_ff <= left_in;
         long_ff <= long_in;
         exit_ff <= exit_in;
         dirty_ff <= dirty_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            type_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      reply_ff <= reply_in;
      if (finish) begin
         out_ff.reply_bytes <= reply_in;
         out_ff.reply_len <= f_len;
         out_ff.data_stage <= f_stage;
         out_ff.transfer_status <= f_status;
         out_ff.connected <= exit_in[1];
         out_ff.keep_running <= exit_in != 2'b00;
         out_ff.start_writeback <= f_wb;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cache_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= cache_mem[mem_raddr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

endmodule

/* sv/isp_programmer_eeprom_cache_engine.sv */
// Vendor-request engine of an ISP programmer serving a serial EEPROM byte cache.
// Events enter on req_chan, results leave on rsp_chan; the EEPROM type byte is
// written through csr_write_enable and csr_write_data. One result per event.
// A front end classifies each event and puts it in a two-entry queue, so the
// request side keeps accepting while the execution unit works or the receiver
// stalls. Each accepted event is queued, popped into the command register,
// executed and its result registered; data-out and data-in events that touch
// the cache take one byte per cycle through the single read and
// single write port of the cache memory; single-cell transmit reads and writes
// add a cell access state. Results sit in an output register until taken;
// while it is full, the execution unit holds the next command and the queue
// fills, then req ready drops. Reset (synchronous, active high) empties the
// queue and restores the programmer state: cache dirty, engine reading,
// transfer idle, type byte 0x66. The cache contents are undefined until written.
module isp_programmer_eeprom_cache_engine (
   input logic       clock,
   input logic       reset,
   ispe_req_if.sink  req_chan,
   ispe_rsp_if.source rsp_chan,
   input logic       csr_write_enable,
   input logic [7:0] csr_write_data
);

   ispe_pkg::cmd_type push_data, pop_data;
   ispe_pkg::rsp_type rsp_data;
   logic push, pop, full, empty;

   ispe_front u_front (
      .valid(req_chan.valid),
      .action(req_chan.action),
      .packet_bytes(req_chan.packet_bytes),
      .packet_len(req_chan.packet_len),
      .engine_idle(req_chan.engine_idle),
      .q_full(full),
      .ready(req_chan.ready),
      .q_push(push),
      .q_data(push_data)
   );

   ispe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .pop_data(pop_data),
      .full(full),
      .empty(empty)
   );

   ispe_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(empty),
      .q_data(pop_data),
      .q_pop(pop),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_data(rsp_data)
   );

   assign rsp_chan.reply_bytes = rsp_data.reply_bytes;
   assign rsp_chan.reply_len = rsp_data.reply_len;
   assign rsp_chan.data_stage = rsp_data.data_stage;
   assign rsp_chan.transfer_status = rsp_data.transfer_status;
   assign rsp_chan.connected = rsp_data.connected;
   assign rsp_chan.keep_running = rsp_data.keep_running;
   assign rsp_chan.start_writeback = rsp_data.start_writeback;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the ISP programmer EEPROM cache engine.
// Depends on ispe_pkg, the ispe_req_if and ispe_rsp_if channels and the top level;
// an in-bench model of the vendor-request state predicts every result.
module tb_top;
   import ispe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_data;

   ispe_req_if req_bus ();
   ispe_rsp_if rsp_bus ();

   isp_programmer_eeprom_cache_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_data)
   );

   localparam int CACHE_SIZE = 512;

   logic [7:0]  cache_img [CACHE_SIZE];
   logic        img_dirty;
   tmode_type   xfer_mode;
   emode_type   eng_mode;
   logic [31:0] stream_ptr;
   logic [15:0] remaining;
   logic        long_mode;
   logic [1:0]  exit_flags;
   logic [7:0]  type_code;

   rsp_type expected_replies[$];
   int errors;
   int items_sent;
   int replies_checked;
   int writebacks_seen;
   int burst_left;
   int stall_mode;
   int rx_cycle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] read_cell(logic [31:0] addr);
      return addr < CACHE_SIZE ? cache_img[addr[8:0]] : ERASED_BYTE;
   endfunction

   function automatic void store_cell(logic [31:0] addr, logic [7:0] v);
      if (addr < CACHE_SIZE && cache_img[addr[8:0]] !== v) begin
         img_dirty = 1'b1;
         cache_img[addr[8:0]] = v;
      end
   endfunction

   function automatic rsp_type predict_reply(logic [1:0] act, logic [63:0] pk,
                                             logic [3:0] len_in, logic eidle);
      rsp_type    res;
      logic [7:0] r [8];
      logic [7:0] vlo, vhi, ilo, ihi;
      logic [7:0] sig [4];
      int         n;
      int         rlen;
      res = '0;
      rlen = 0;
      n = len_in > 8 ? 8 : len_in;
      sig[0] = 8'h1e; sig[1] = 8'h93; sig[2] = 8'h07; sig[3] = 8'h00;
      for (int i = 0; i < 8; i++) r[i] = 8'h00;
      vlo = pk[23:16]; vhi = pk[31:24]; ilo = pk[39:32]; ihi = pk[47:40];
      case (act)
         ACT_SETUP: begin
            if ((pk[7:0] & 8'h60) == 8'h40) begin
               case (pk[15:8])
                  REQ_CONNECT: begin
                     long_mode = 1'b0;
                     exit_flags[1] = 1'b1;
                  end
                  REQ_DISCONNECT: begin
                     exit_flags[1] = 1'b0;
                     if (img_dirty && eidle && eng_mode == EM_IDLE) begin
                        eng_mode = EM_WRITE;
                        res.start_writeback = 1'b1;
                     end
                  end
                  REQ_ENABLE: begin
                     r[0] = {7'd0, eng_mode != EM_IDLE};
                     rlen = 1;
                  end
                  REQ_SET_CLOCK: rlen = 1;
                  REQ_TRANSMIT: begin
                     rlen = 4;
                     if (vlo == TX_SIG) r[3] = sig[ilo[1:0]];
                     else if ({vhi, vlo} == 16'hffff && {ihi, ilo} == 16'hffff)
                        exit_flags[0] = 1'b0;
                     else if (vlo == TX_FF && vhi == 8'h00) exit_flags[0] = 1'b0;
                     else if ({vhi, vlo} == 16'hffff && {ihi, ilo} == TX_TYPE_IDX) begin
                        r[0] = TYPE_B0; r[1] = TYPE_B1; r[2] = TYPE_B2; r[3] = type_code;
                     end
                     else if (vlo == TX_FUSE && vhi == 8'h00) r[3] = FUSE_VALUE;
                     else if (vlo == TX_LFUSE && vhi == 8'h00) r[3] = FUSE_VALUE;
                     else if (vlo == TX_FUSE && vhi == TX_HI_FUSE) r[3] = LOCK_VALUE;
                     else if (vlo == TX_RD_CELL && vhi[7:1] == 7'd0)
                        r[3] = read_cell({23'd0, vhi[0], ilo});
                     else if (vlo == TX_WR_CELL && vhi[7:1] == 7'd0)
                        store_cell({23'd0, vhi[0], ilo}, ihi);
                     else r[3] = ERASED_BYTE;
                  end
                  REQ_LONG_ADDR: begin
                     long_mode = 1'b1;
                     stream_ptr = pk[47:16];
                  end
                  REQ_WRITE_FLASH: begin
                     remaining = pk[63:48];
                     xfer_mode = TM_WFLASH;
                     res.data_stage = 1'b1;
                  end
                  REQ_READ_FLASH, REQ_READ_EE, REQ_WRITE_EE: begin
                     if (!long_mode) stream_ptr = {16'd0, pk[31:16]};
                     remaining = pk[63:48];
                     xfer_mode = pk[15:8] == REQ_READ_FLASH ? TM_RFLASH :
                                 pk[15:8] == REQ_READ_EE ? TM_REE : TM_WEE;
                     res.data_stage = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ACT_DATA_OUT: begin
            if (xfer_mode == TM_WFLASH) begin
               if (remaining > n) remaining = remaining - n;
               else begin
                  remaining = '0;
                  xfer_mode = TM_IDLE;
                  res.transfer_status = ST_COMPLETE;
               end
            end else if (xfer_mode == TM_WEE) begin
               for (int i = 0; i < n; i++) begin
                  store_cell(stream_ptr, pk[8*i +: 8]);
                  stream_ptr++;
                  remaining--;
                  if (remaining == 0) begin
                     xfer_mode = TM_IDLE;
                     res.transfer_status = ST_COMPLETE;
                     break;
                  end
               end
            end else res.transfer_status = ST_WRONG;
         end
         ACT_DATA_IN: begin
            if (xfer_mode == TM_RFLASH || xfer_mode == TM_REE) begin
               for (int i = 0; i < n; i++) begin
                  r[i] = xfer_mode == TM_REE ? read_cell(stream_ptr) : ERASED_BYTE;
                  stream_ptr++;
               end
               if (n < 8) xfer_mode = TM_IDLE;
               rlen = n;
            end else res.transfer_status = ST_WRONG;
         end
         default: begin
            if (eng_mode != EM_IDLE) img_dirty = 1'b0;
            eng_mode = EM_IDLE;
         end
      endcase
      for (int i = 0; i < rlen; i++) res.reply_bytes[8*i +: 8] = r[i];
      res.reply_len = rlen[3:0];
      res.connected = exit_flags[1];
      res.keep_running = exit_flags != 2'b00;
      return res;
   endfunction

   function automatic logic [63:0] setup_pkt(logic [7:0] rtype, logic [7:0] req,
                                             logic [15:0] val, logic [15:0] idx,
                                             logic [15:0] wlen);
      return {wlen, idx, val, req, rtype};
   endfunction

   // Called at a falling edge; returns at a falling edge with valid possibly still high.
   task automatic send_event(logic [1:0] act, logic [63:0] pk, logic [3:0] len,
                             logic eidle);
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.packet_bytes <= pk;
      req_bus.packet_len <= len;
      req_bus.engine_idle <= eidle;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_replies.push_back(predict_reply(act, pk, len, eidle));
      items_sent++;
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80)
                                                : $urandom_range(0, 12);
      end
   endtask

   task automatic vendor(logic [7:0] req, logic [15:0] val, logic [15:0] idx,
                         logic [15:0] wlen);
      send_event(ACT_SETUP, setup_pkt(8'h40, req, val, idx, wlen), 4'd0, 1'b1);
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_type(logic [7:0] v);
      drain();
      csr_we <= 1'b1;
      csr_data <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_data <= $urandom_range(0, 255);
      type_code = v;
   endtask

   task automatic test_cache_fill;
      vendor(REQ_WRITE_EE, 16'd0, 16'd0, CACHE_SIZE[15:0]);
      for (int p = 0; p < CACHE_SIZE / 8; p++)
         send_event(ACT_DATA_OUT, {$urandom, $urandom}, 4'd8, 1'b0);
   endtask

   task automatic test_directed;
      send_event(ACT_SETUP, setup_pkt(8'h00, REQ_CONNECT, 0, 0, 0), 4'd0, 1'b1);
      vendor(REQ_CONNECT, 16'd0, 16'd0, 16'd0);
      vendor(REQ_ENABLE, 16'd0, 16'd0, 16'd0);
      vendor(REQ_SET_CLOCK, 16'd0, 16'd0, 16'd0);
      vendor(8'hff, 16'hffff, 16'hffff, 16'hffff);
      for (int s = 0; s < 4; s++) vendor(REQ_TRANSMIT, {8'h00, TX_SIG}, s[15:0], 0);
      vendor(REQ_TRANSMIT, 16'hffff, TX_TYPE_IDX, 16'd0);
      vendor(REQ_TRANSMIT, {8'h00, TX_FUSE}, 16'd0, 16'd0);
      vendor(REQ_TRANSMIT, {8'h00, TX_LFUSE}, 16'd0, 16'd0);
      vendor(REQ_TRANSMIT, {TX_HI_FUSE, TX_FUSE}, 16'd0, 16'd0);
      vendor(REQ_TRANSMIT, {8'h01, TX_RD_CELL}, 16'h00ff, 16'd0);
      vendor(REQ_TRANSMIT, {8'h02, 8'h12}, 16'd0, 16'd0);
      send_event(ACT_DATA_OUT, '1, 4'd8, 1'b1);
      send_event(ACT_DATA_IN, '0, 4'd8, 1'b1);
      send_event(ACT_ENG_DONE, '0, 4'd0, 1'b1);
      send_event(ACT_ENG_DONE, '0, 4'd0, 1'b1);
      vendor(REQ_DISCONNECT, 16'd0, 16'd0, 16'd0);
      vendor(REQ_TRANSMIT, {8'h00, TX_WR_CELL}, {~cache_img[5], 8'h05}, 16'd0);
      send_event(ACT_SETUP, setup_pkt(8'h40, REQ_DISCONNECT, 0, 0, 0), 4'd0, 1'b0);
      vendor(REQ_DISCONNECT, 16'd0, 16'd0, 16'd0);
      vendor(REQ_LONG_ADDR, 16'hfffc, 16'hffff, 16'd0);
      vendor(REQ_READ_EE, 16'd0, 16'd0, 16'd20);
      send_event(ACT_DATA_IN, '0, 4'd15, 1'b1);
      send_event(ACT_DATA_IN, '0, 4'd0, 1'b1);
      vendor(REQ_TRANSMIT, 16'h00ff, 16'd0, 16'd0);
      vendor(REQ_TRANSMIT, 16'hffff, 16'hffff, 16'd0);
   endtask

   task automatic test_type_register;
      logic [7:0] codes [6];
      codes[0] = 8'h00; codes[1] = 8'hff; codes[2] = 8'h46;
      codes[3] = 8'h56; codes[4] = 8'h80; codes[5] = 8'h66;
      foreach (codes[c]) begin
         write_type(codes[c]);
         vendor(REQ_TRANSMIT, 16'hffff, TX_TYPE_IDX, 16'd0);
         vendor(REQ_WRITE_FLASH, 16'd0, 16'd0, 16'd0);
         send_event(ACT_DATA_OUT, '0, 4'd3, 1'b1);
      end
   endtask

   task automatic test_streams;
      logic [7:0]  vlo, vhi;
      logic [63:0] pk;
      int          k, guard;
      while (items_sent < 1550) begin
         k = $urandom_range(0, 99);
         if (k < 36) begin
            if ($urandom_range(0, 7) == 0)
               vendor(REQ_LONG_ADDR, $urandom_range(0, 1) ? 16'hfff0 : $urandom,
                      $urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'd0);
            else if (long_mode) vendor(REQ_CONNECT, 16'd0, 16'd0, 16'd0);
            if (k < 18) begin
               vendor(REQ_READ_EE, $urandom_range(0, 530), 16'd0, $urandom_range(1, 40));
               guard = 0;
               while (xfer_mode == TM_REE && guard < 12) begin
                  send_event(ACT_DATA_IN, '0,
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 4'd8,
                             $urandom_range(0, 1));
                  guard++;
               end
            end else begin
               vendor(REQ_WRITE_EE, $urandom_range(0, 530), 16'd0,
                      $urandom_range(0, 30) == 0 ? 16'd0 : $urandom_range(1, 40));
               guard = 0;
               while (xfer_mode == TM_WEE && guard < 10) begin
                  pk = {$urandom, $urandom};
                  if ($urandom_range(0, 1))
                     for (int i = 0; i < 8; i++)
                        pk[8*i +: 8] = read_cell(stream_ptr + i);
                  send_event(ACT_DATA_OUT, pk, $urandom_range(0, 15), $urandom_range(0, 1));
                  guard++;
               end
            end
         end else if (k < 44) begin
            vendor(REQ_READ_FLASH, $urandom, 16'd0, $urandom_range(1, 40));
            repeat ($urandom_range(1, 4))
               send_event(ACT_DATA_IN, '0, $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (k < 50) begin
            vendor(REQ_WRITE_FLASH, $urandom, $urandom, $urandom_range(0, 30));
            repeat ($urandom_range(1, 5))
               send_event(ACT_DATA_OUT, {$urandom, $urandom}, $urandom_range(0, 15), 1'b1);
         end else if (k < 66) begin
            case ($urandom_range(0, 7))
               0: vlo = TX_SIG;
               1: vlo = TX_FF;
               2: vlo = TX_FUSE;
               3: vlo = TX_LFUSE;
               4: vlo = TX_RD_CELL;
               5: vlo = TX_WR_CELL;
               default: vlo = $urandom;
            endcase
            case ($urandom_range(0, 4))
               0, 1: vhi = 8'h00;
               2: vhi = 8'h01;
               3: vhi = $urandom_range(0, 1) ? TX_HI_FUSE : 8'hff;
               default: vhi = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
               vendor(REQ_TRANSMIT, 16'hffff, $urandom_range(0, 1) ? TX_TYPE_IDX : 16'hffff,
                      $urandom);
            else send_event(ACT_SETUP,
                            setup_pkt({$urandom_range(0, 1), 2'b10, 5'($urandom)},
                                      REQ_TRANSMIT, {vhi, vlo}, $urandom, $urandom),
                            $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (k < 74) begin
            case ($urandom_range(0, 3))
               0: vendor(REQ_CONNECT, $urandom, $urandom, $urandom);
               1: send_event(ACT_SETUP, setup_pkt(8'h40, REQ_DISCONNECT, 0, 0, 0),
                             4'd0, $urandom_range(0, 3) != 0);
               2: vendor(REQ_ENABLE, $urandom, $urandom, $urandom);
               default: vendor(REQ_SET_CLOCK, $urandom, $urandom, $urandom);
            endcase
         end else if (k < 82) begin
            send_event(ACT_ENG_DONE, {$urandom, $urandom}, $urandom, $urandom_range(0, 1));
         end else begin
            send_event($urandom_range(0, 3), {$urandom, $urandom}, $urandom_range(0, 15),
                       $urandom_range(0, 1));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_data = 8'h00;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_SETUP;
      req_bus.packet_bytes = '0;
      req_bus.packet_len = '0;
      req_bus.engine_idle = 1'b0;
      rsp_bus.ready = 1'b0;
      errors = 0;
      items_sent = 0;
      replies_checked = 0;
      writebacks_seen = 0;
      burst_left = 0;
      img_dirty = 1'b1;
      xfer_mode = TM_IDLE;
      eng_mode = EM_READ;
      stream_ptr = '0;
      remaining = '0;
      long_mode = 1'b0;
      exit_flags = 2'b01;
      type_code = EE_TYPE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_cache_fill();
      test_directed();
      test_type_register();
      write_type($urandom);
      test_streams();
      drain();
      $display("%0d events sent, %0d results checked, %0d writebacks requested",
               items_sent, replies_checked, writebacks_seen);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(0, 3) != 0;
         2: rsp_bus.ready <= $urandom_range(0, 3) == 0;
         default: rsp_bus.ready <= (rx_cycle % 7) > 2;
      endcase
   end

   initial begin
      rx_cycle = 0;
      stall_mode = 0;
   end

   function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, expected none, actual %h", $time,
                     rsp_bus.reply_bytes);
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (rsp_bus.start_writeback) writebacks_seen++;
            check_field("reply_bytes", want.reply_bytes, rsp_bus.reply_bytes);
            check_field("reply_len", want.reply_len, rsp_bus.reply_len);
            check_field("data_stage", want.data_stage, rsp_bus.data_stage);
            check_field("transfer_status", want.transfer_status, rsp_bus.transfer_status);
            check_field("connected", want.connected, rsp_bus.connected);
            check_field("keep_running", want.keep_running, rsp_bus.keep_running);
            check_field("start_writeback", want.start_writeback, rsp_bus.start_writeback);
         end
      end
   end
endmodule
